@@ rtl/fcf_pkg.sv @@
// shared types and constants of the fir convolution filter
`default_nettype none

package fcf_pkg;

    // field widths
    localparam int SAMPLE_W    = 24;
    localparam int GAIN_W      = 24;
    localparam int TAP_COUNT_W = 11;
    localparam int TAP_INDEX_W = 10;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;
    localparam int PROD_W      = 2 * SAMPLE_W;

    // defaults and limits
    localparam int DEF_MAX_TAPS = 1024;
    localparam int MIN_TAPS     = 3;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    // fixed point scaling
    localparam int ACC_FRAC  = 23;
    localparam int GAIN_FRAC = 16;
    localparam int SPLIT_W   = 17;

    // saturation bounds
    localparam int SAT_MAX = 8388607;
    localparam int SAT_MIN = -8388608;

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TAP_COUNT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_GAIN = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_MAC,
        S_ROUND,
        S_MUL,
        S_SCALE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/fcf_ram.sv @@
// generic single write, single read ram with registered read data
`default_nettype none

module fcf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/fir_convolution_filter.sv @@
// direct form fir filter over a circular delay line held in ram
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  in      | in        | i_in_valid / o_in_stall    | i_cmd, i_tap_index, i_value
//  out     | out       | o_out_valid / i_out_stall  | o_filtered_sample
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// a coefficient word is written as it is taken; a sample word with fewer than three taps in
// use passes through. a sample word with n taps steps through write, mac, round, mul, scale
// and emit: one multiply-accumulate per tap, bounded by the single read port of each of the
// delay and coefficient rams. after reset the delay ram is cleared while the input is stalled.
// the result sits in an output register, so the next word is taken while it waits.
`default_nettype none

module fir_convolution_filter #(
    parameter int MAX_TAPS = fcf_pkg::DEF_MAX_TAPS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input words
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_cmd,
    input  wire logic [fcf_pkg::TAP_INDEX_W-1:0]   i_tap_index,
    input  wire logic signed [fcf_pkg::SAMPLE_W-1:0] i_value,
    // result words
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [fcf_pkg::SAMPLE_W-1:0]    o_filtered_sample,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [fcf_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [fcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import fcf_pkg::*;

    localparam int AW    = $clog2(MAX_TAPS);
    localparam int CW    = (AW + 1 > TAP_COUNT_W) ? AW + 1 : TAP_COUNT_W;
    localparam int IXW   = ((AW > TAP_INDEX_W) ? AW : TAP_INDEX_W) + 1;
    localparam int ACC_W = PROD_W + AW;
    localparam int R1_W  = ACC_W - ACC_FRAC;
    localparam int HI_W  = R1_W - SPLIT_W;
    localparam int PHI_W = HI_W + GAIN_W + 1;
    localparam int PLO_W = SPLIT_W + GAIN_W;
    localparam int SUM_W = PHI_W + SPLIT_W + 1;
    localparam int Q_W   = SUM_W - GAIN_FRAC;

    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) <<< (ACC_FRAC - 1);
    localparam logic signed [SUM_W-1:0] SUM_HALF = SUM_W'(1) <<< (GAIN_FRAC - 1);
    localparam logic signed [Q_W-1:0]   Q_MAX    = Q_W'(SAT_MAX);
    localparam logic signed [Q_W-1:0]   Q_MIN    = Q_W'(SAT_MIN);
    localparam logic [AW-1:0]           LAST_ADDR = AW'(MAX_TAPS - 1);

    // state registers
    t_state r_state;
    t_state n_state;

    logic [TAP_COUNT_W-1:0]    r_tap_count;
    logic [GAIN_W-1:0]         r_gain;
    logic [AW-1:0]             r_wp;
    logic [AW-1:0]             r_clr_addr;
    logic [CW-1:0]             r_taps;
    logic [CW-1:0]             r_k;
    logic [AW-1:0]             r_s;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                      r_rd_v;
    logic                      r_mul_v;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [R1_W-1:0]    r_r1;
    logic signed [PHI_W-1:0]   r_phi;
    logic [PLO_W-1:0]          r_plo;
    logic signed [SAMPLE_W-1:0] r_result;
    logic                      r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data;

    // combinational helpers
    logic                      w_in_acc;
    logic                      w_out_free;
    logic [CW-1:0]             w_tc_ext;
    logic [CW-1:0]             w_n_use;
    logic                      w_short;
    logic [CW-1:0]             w_wp_inc;
    logic [AW-1:0]             w_pos;
    logic [IXW-1:0]            w_idx_ext;
    logic                      w_idx_ok;
    logic                      w_issue;
    logic                      w_mac_done;
    logic [CW-1:0]             w_taps_m1;
    logic signed [ACC_W-1:0]   w_acc_rnd;
    logic signed [HI_W-1:0]    w_hi;
    logic [SPLIT_W-1:0]        w_lo;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [Q_W-1:0]     w_q;
    logic signed [SAMPLE_W-1:0] w_sat;

    // memory ports
    logic                      w_dly_we;
    logic [AW-1:0]             w_dly_waddr;
    logic [SAMPLE_W-1:0]       w_dly_wdata;
    logic [SAMPLE_W-1:0]       w_dly_rdata;
    logic                      w_coef_we;
    logic [SAMPLE_W-1:0]       w_coef_rdata;

    // handshakes
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // taps in use, saturated at the ram depth
    assign w_tc_ext = CW'(r_tap_count);
    assign w_n_use  = (w_tc_ext > CW'(MAX_TAPS)) ? CW'(MAX_TAPS) : w_tc_ext;
    assign w_short  = (w_n_use < CW'(MIN_TAPS));

    // next write position, wrapping at the taps in use
    assign w_wp_inc = CW'(r_wp) + CW'(1);
    assign w_pos    = (w_wp_inc >= w_n_use) ? '0 : w_wp_inc[AW-1:0];

    // coefficient index range check
    assign w_idx_ext = IXW'(i_tap_index);
    assign w_idx_ok  = (w_idx_ext < IXW'(MAX_TAPS));

    // multiply-accumulate sequencing
    assign w_issue    = (r_state == S_MAC) && (r_k != r_taps);
    assign w_mac_done = (r_k == r_taps) && !r_rd_v && !r_mul_v;
    assign w_taps_m1  = r_taps - CW'(1);

    // rounding of the sum and split for the gain multiply
    assign w_acc_rnd = r_acc + ACC_HALF;
    assign w_hi      = r_r1[R1_W-1:SPLIT_W];
    assign w_lo      = r_r1[SPLIT_W-1:0];

    // recombine partial products, round and saturate
    assign w_sum = (SUM_W'(r_phi) <<< SPLIT_W) + SUM_W'(r_plo) + SUM_HALF;
    assign w_q   = w_sum[SUM_W-1:GAIN_FRAC];
    always_comb begin
        if (w_q > Q_MAX) begin
            w_sat = Q_MAX[SAMPLE_W-1:0];
        end else if (w_q < Q_MIN) begin
            w_sat = Q_MIN[SAMPLE_W-1:0];
        end else begin
            w_sat = w_q[SAMPLE_W-1:0];
        end
    end

    // delay ram write: clearing sweep or new sample
    always_comb begin
        w_dly_we    = 1'b0;
        w_dly_waddr = r_wp;
        w_dly_wdata = r_sample;
        if (r_state == S_CLEAR) begin
            w_dly_we    = 1'b1;
            w_dly_waddr = r_clr_addr;
            w_dly_wdata = '0;
        end else if (r_state == S_WRITE) begin
            w_dly_we = 1'b1;
        end
    end

    assign w_coef_we = w_in_acc && (i_cmd == CMD_COEF) && w_idx_ok;

    fcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (w_dly_we),
        .i_waddr (w_dly_waddr),
        .i_wdata (w_dly_wdata),
        .i_raddr (r_s),
        .o_rdata (w_dly_rdata)
    );

    fcf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_TAPS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (i_value),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (w_coef_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc && (i_cmd == CMD_SAMPLE)) begin
                    n_state = w_short ? S_EMIT : S_WRITE;
                end
            end
            S_WRITE: n_state = S_MAC;
            S_MAC: begin
                if (w_mac_done) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_MUL;
            S_MUL:   n_state = S_SCALE;
            S_SCALE: n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= '0;
            r_gain      <= GAIN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TAP_COUNT:   r_tap_count <= i_cfg_data[TAP_COUNT_W-1:0];
                REG_OUTPUT_GAIN: r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_clr_addr  <= '0;
            r_k         <= '0;
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // clearing sweep
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            // new sample word starts the tap walk
            if (w_in_acc && (i_cmd == CMD_SAMPLE) && !w_short) begin
                r_wp <= w_pos;
                r_k  <= '0;
            end
            if (w_issue) begin
                r_k <= r_k + CW'(1);
            end
            r_rd_v  <= w_issue;
            r_mul_v <= r_rd_v;
            // output register
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == CMD_SAMPLE)) begin
            r_sample <= i_value;
            r_result <= i_value;
            r_taps   <= w_n_use;
            r_s      <= w_pos;
        end
        // delay line walks backwards around the ring
        if (w_issue) begin
            r_s <= (r_s == '0) ? w_taps_m1[AW-1:0] : r_s - AW'(1);
        end
        r_prod <= $signed(w_dly_rdata) * $signed(w_coef_rdata);
        if (r_state == S_WRITE) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (r_state == S_ROUND) begin
            r_r1 <= w_acc_rnd[ACC_W-1:ACC_FRAC];
        end
        // gain multiply as two partial products
        if (r_state == S_MUL) begin
            r_phi <= w_hi * $signed({1'b0, r_gain});
            r_plo <= w_lo * r_gain;
        end
        if (r_state == S_SCALE) begin
            r_result <= w_sat;
        end
        if (r_state == S_EMIT && w_out_free) begin
            r_out_data <= r_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_filtered_sample = r_out_data;

endmodule

`default_nettype wire

@@ tb/tb_fir_convolution_filter.sv @@
// self-checking testbench of the direct form fir convolution filter
`timescale 1ns / 1ps

module tb_fir_convolution_filter;
    import fcf_pkg::*;

    localparam int WATCHDOG_LIMIT = 12000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int RANDOM_WORDS   = 440;
    localparam int CALM_WORDS     = 40;

    // directed plan
    typedef enum logic [1:0] {
        ROW_SAMPLE,
        ROW_COEF,
        ROW_REG
    } t_row_kind;

    typedef struct packed {
        t_row_kind               kind;
        logic [TAP_INDEX_W-1:0]  index;
        logic [SAMPLE_W-1:0]     value;
        logic                    fixed;
        logic [SAMPLE_W-1:0]     want;
    } t_row;

    localparam int PLAN_LEN = 24;
    localparam t_row PLAN [PLAN_LEN] = '{
        // pass-through straight after reset
        '{ROW_SAMPLE, 10'd0,    24'h7FFFFF, 1'b1, 24'h7FFFFF},
        '{ROW_SAMPLE, 10'd0,    24'h800000, 1'b1, 24'h800000},
        '{ROW_SAMPLE, 10'd0,    24'h000001, 1'b1, 24'h000001},
        // extreme coefficients, lowest and highest tap index
        '{ROW_COEF,   10'd0,    24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_COEF,   10'd1,    24'h800000, 1'b0, 24'h0},
        '{ROW_COEF,   10'd2,    24'h400000, 1'b0, 24'h0},
        '{ROW_COEF,   10'd1023, 24'h5A5A5A, 1'b0, 24'h0},
        // two taps is still a short filter
        '{ROW_REG,    10'(REG_TAP_COUNT), 24'd2, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h003039, 1'b1, 24'h003039},
        // shortest real filter
        '{ROW_REG,    10'(REG_TAP_COUNT), 24'd3, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h800000, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h800000, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h000000, 1'b0, 24'h0},
        // full scale gain drives both saturation bounds
        '{ROW_REG,    10'(REG_OUTPUT_GAIN), 24'hFFFFFF, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h7FFFFF, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h800000, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h123456, 1'b0, 24'h0},
        // zero gain silences the output
        '{ROW_REG,    10'(REG_OUTPUT_GAIN), 24'h000000, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h7FFFFF, 1'b1, 24'h000000},
        // unity gain, count written with junk above its width
        '{ROW_REG,    10'(REG_OUTPUT_GAIN), 24'h010000, 1'b0, 24'h0},
        '{ROW_REG,    10'(REG_TAP_COUNT), 24'hFFF803, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'hABCDEF, 1'b0, 24'h0},
        '{ROW_SAMPLE, 10'd0,    24'h00FFFF, 1'b0, 24'h0}
    };

    // block signals
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_cmd = CMD_SAMPLE;
    logic [TAP_INDEX_W-1:0]        i_tap_index = '0;
    logic signed [SAMPLE_W-1:0]    i_value = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]    o_filtered_sample;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_INDEX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    // shadow of the filter state
    logic signed [SAMPLE_W-1:0]    line_mem [DEF_MAX_TAPS];
    logic signed [SAMPLE_W-1:0]    tap_mem [DEF_MAX_TAPS];
    bit                            tap_loaded [DEF_MAX_TAPS];
    logic [TAP_INDEX_W-1:0]        line_head = '0;
    logic [TAP_COUNT_W-1:0]        taps_in_use = '0;
    logic [GAIN_W-1:0]             gain_q16 = GAIN_RESET;

    logic signed [SAMPLE_W-1:0]    filtered_due [$];
    logic signed [SAMPLE_W-1:0]    due_word;
    int                            mismatches = 0;
    int                            idle_run = 0;
    int                            quiet_words = 0;
    int                            random_words = 0;
    bit                            calm = 1'b0;
    bit                            squeeze_req = 1'b0;
    bit                            squeeze_done = 1'b0;

    fir_convolution_filter i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_tap_index       (i_tap_index),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_filtered_sample (o_filtered_sample),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // expected filter output for one sample word, advancing the shadow state
    function automatic logic signed [SAMPLE_W-1:0] convolve_sample(
        logic signed [SAMPLE_W-1:0] smp
    );
        int     n;
        int     pos;
        int     s;
        longint acc;
        longint scaled;
        n = (taps_in_use > DEF_MAX_TAPS) ? DEF_MAX_TAPS : int'(taps_in_use);
        if (n < MIN_TAPS) begin
            return smp;
        end
        // step forward, a stale head wraps to the start
        pos = int'(line_head) + 1;
        if (pos >= n) begin
            pos = 0;
        end
        line_head = TAP_INDEX_W'(pos);
        line_mem[pos] = smp;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            s = (pos >= k) ? pos - k : pos + n - k;
            acc += longint'(line_mem[s]) * longint'(tap_mem[k]);
        end
        // round to q.23, apply gain, round again and clamp
        acc = (acc + (64'sd1 <<< (ACC_FRAC - 1))) >>> ACC_FRAC;
        scaled = acc * longint'(gain_q16);
        scaled = (scaled + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (scaled > SAT_MAX) begin
            scaled = SAT_MAX;
        end else if (scaled < SAT_MIN) begin
            scaled = SAT_MIN;
        end
        return SAMPLE_W'(scaled);
    endfunction

    // random coefficient, mostly scaled down so sums stay in range
    function automatic logic signed [SAMPLE_W-1:0] pick_tap();
        logic signed [SAMPLE_W-1:0] c;
        c = SAMPLE_W'($urandom());
        case ($urandom_range(0, 9))
            0: return c;
            1: return 24'h7FFFFF;
            default: return c >>> $urandom_range(2, 10);
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic signed [SAMPLE_W-1:0] got,
                                 logic signed [SAMPLE_W-1:0] want);
        $display("mismatch (%s): got %0d, want %0d", what, got, want);
        mismatches++;
    endtask

    // offer one input word and book what it should produce
    task automatic push_word(logic cmd, logic [TAP_INDEX_W-1:0] index,
                             logic [SAMPLE_W-1:0] value, logic fixed,
                             logic [SAMPLE_W-1:0] want);
        int gap;
        logic signed [SAMPLE_W-1:0] due;
        gap = 0;
        if (!calm) begin
            if (quiet_words > 0) begin
                quiet_words--;
            end else if ($urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 17);
            end else if ($urandom_range(0, 19) == 0) begin
                quiet_words = $urandom_range(10, 40);
            end
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_cmd       <= cmd;
        i_tap_index <= index;
        i_value     <= value;
        do @(posedge i_clk); while (o_in_stall);
        if (cmd == CMD_COEF) begin
            tap_mem[index]    = value;
            tap_loaded[index] = 1'b1;
        end else begin
            due = convolve_sample(value);
            filtered_due.push_back(fixed ? want : due);
        end
        @(negedge i_clk);
    endtask

    // register write through the configuration channel
    task automatic write_reg(logic [CFG_INDEX_W-1:0] which, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (which)
            REG_TAP_COUNT:   taps_in_use = data[TAP_COUNT_W-1:0];
            REG_OUTPUT_GAIN: gain_q16 = data[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // drain all results and let the block go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (filtered_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one setting of the registers followed by a stream of words
    task automatic run_phase(int taps, int words, bit squeeze);
        logic [CFG_DATA_W-1:0]      gain;
        logic [CFG_DATA_W-1:0]      count_word;
        logic signed [SAMPLE_W-1:0] smp;
        int                         fill;
        settle();
        case ($urandom_range(0, 5))
            0: gain = '0;
            1: gain = '1;
            2: gain = CFG_DATA_W'($urandom());
            default: gain = CFG_DATA_W'($urandom_range(1 << 14, 1 << 18));
        endcase
        count_word = CFG_DATA_W'(taps);
        if ($urandom_range(0, 1) == 1) begin
            count_word[CFG_DATA_W-1:TAP_COUNT_W] = (CFG_DATA_W - TAP_COUNT_W)'($urandom());
        end
        if ($urandom_range(0, 1) == 1) begin
            write_reg(REG_TAP_COUNT, count_word);
            write_reg(REG_OUTPUT_GAIN, gain);
        end else begin
            write_reg(REG_OUTPUT_GAIN, gain);
            write_reg(REG_TAP_COUNT, count_word);
        end
        // every tap in use must hold a coefficient first
        fill = (taps < DEF_MAX_TAPS) ? taps : DEF_MAX_TAPS;
        for (int i = 0; i < fill; i++) begin
            if (!tap_loaded[i]) begin
                push_word(CMD_COEF, TAP_INDEX_W'(i), pick_tap(), 1'b0, '0);
            end
        end
        if (squeeze) begin
            squeeze_req = 1'b1;
        end
        repeat (words) begin
            if ($urandom_range(0, 6) == 0) begin
                push_word(CMD_COEF, TAP_INDEX_W'($urandom_range(0, DEF_MAX_TAPS - 1)),
                          pick_tap(), 1'b0, '0);
            end else begin
                case ($urandom_range(0, 7))
                    0: smp = 24'h7FFFFF;
                    1: smp = 24'h800000;
                    2: smp = SAMPLE_W'($urandom_range(0, 511)) - 24'sd256;
                    default: smp = SAMPLE_W'($urandom());
                endcase
                push_word(CMD_SAMPLE, TAP_INDEX_W'($urandom()), smp, 1'b0, '0);
            end
            random_words++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (filtered_due.size() == 0) begin
                flag_mismatch("no result due", o_filtered_sample, '0);
            end else begin
                due_word = filtered_due.pop_front();
                if (o_filtered_sample !== due_word) begin
                    flag_mismatch("filtered_sample", o_filtered_sample, due_word);
                end
            end
        end
    end

    // watchdog on cycles where no word moves on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_run = 0;
        end else begin
            idle_run++;
        end
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("[fir_convolution_filter] ERROR");
            $finish;
        end
    end

    // receiver stalls: random bursts, quiet stretches and one long hold-off
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (squeeze_req && !squeeze_done) begin
                i_out_stall <= 1'b1;
                repeat (SQUEEZE_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
                squeeze_done = 1'b1;
            end else if (!calm) begin
                if ($urandom_range(0, 7) == 0) begin
                    burst = $urandom_range(1, 17);
                    i_out_stall <= 1'b1;
                    repeat (burst) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    repeat ($urandom_range(20, 80)) @(negedge i_clk);
                end
            end
        end
    end

    // stimulus
    initial begin
        int phase;
        foreach (line_mem[i]) begin
            line_mem[i]   = '0;
            tap_mem[i]    = '0;
            tap_loaded[i] = 1'b0;
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan
        for (int r = 0; r < PLAN_LEN; r++) begin
            case (PLAN[r].kind)
                ROW_REG: begin
                    settle();
                    write_reg(PLAN[r].index[CFG_INDEX_W-1:0], PLAN[r].value);
                end
                ROW_COEF:
                    push_word(CMD_COEF, PLAN[r].index, PLAN[r].value, 1'b0, '0);
                default:
                    push_word(CMD_SAMPLE, PLAN[r].index, PLAN[r].value,
                              PLAN[r].fixed, PLAN[r].want);
            endcase
        end

        // random phases, mostly short filters, one longer pass
        phase = 0;
        while (random_words < RANDOM_WORDS) begin
            if (phase == 0) begin
                run_phase($urandom_range(0, MIN_TAPS - 1), 30, 1'b0);
            end else if (phase == 2) begin
                run_phase($urandom_range(MIN_TAPS, 12), 60, 1'b1);
            end else if (phase == 5) begin
                run_phase($urandom_range(40, 64), 12, 1'b0);
            end else if (phase % 4 == 3) begin
                run_phase(MIN_TAPS, $urandom_range(25, 50), 1'b0);
            end else begin
                run_phase($urandom_range(MIN_TAPS + 1, 24), $urandom_range(25, 50), 1'b0);
            end
            phase++;
        end

        // closing stretch at full rate
        calm = 1'b1;
        run_phase($urandom_range(MIN_TAPS, 16), CALM_WORDS, 1'b0);
        settle();

        if (mismatches == 0 && filtered_due.size() == 0) begin
            $display("[fir_convolution_filter] OK");
        end else begin
            $display("[fir_convolution_filter] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/fcf_pkg.sv
rtl/fcf_ram.sv
rtl/fir_convolution_filter.sv
tb/tb_fir_convolution_filter.sv
